// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Transaction structs, command and status codes, and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int PRIORITY_BITS_DEF = 16;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [31:0] item_data;
    logic signed [15:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic signed [31:0] front_data;
    logic        [1:0]  status;
    logic               is_empty;
    logic        [4:0]  fill_count;
  } spq_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;  // insert the new entry (queue not full)
    logic deq;  // shift everything one place towards the front
  } spq_ctl_t;

endpackage : spq_pkg

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: stable bounded priority queue
// A row of cells kept in ascending priority order; smaller priority first,
// first in first out among equal priorities.
// ----------------------------------------------------------------------------
//
//   channel | ports                      | handshake
//   --------+----------------------------+------------------------------------
//   input   | start, busy, in_item       | taken when start high, busy low
//   result  | out_strobe, out_result     | one-cycle strobe, cannot be held off
//
// Cycles: one transaction per clock. busy is held low; every cell compares
// against the new priority in parallel, so the whole chain updates together.
// Latency: the result appears the cycle after start (registered outputs).
// Reset: rst_n synchronous, active low; clears the fill count and the strobe.
// Cell contents are not reset; only slots below the fill count are read.
// Stalls: none on either side; the receiver must take each result as shown.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire spq_in_t  in_item,
  output logic          out_strobe,
  output spq_out_t      out_result
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // fill count and result register
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_strobe_r;
  spq_out_t         out_r, out_nxt;

  // chain wiring
  logic signed [31:0]              cell_data [QUEUE_DEPTH];
  logic signed [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]          cell_keep;
  logic [QUEUE_DEPTH-1:0]          cell_occ;

  logic signed [PRIORITY_BITS-1:0] new_prio;
  logic                            accept;
  logic                            is_full, is_none;
  spq_ctl_t                        ctl;
  logic [CNT_W+4:0]                count_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // priority field narrowed or sign-extended to the stored width
  generate
    if (PRIORITY_BITS <= 16) begin : g_prio_narrow
      assign new_prio = in_item.item_priority[PRIORITY_BITS-1:0];
    end else begin : g_prio_wide
      assign new_prio = PRIORITY_BITS'(in_item.item_priority);
    end
  endgenerate

  assign is_full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_none = (count_r == '0);

  assign ctl.enq = accept && (in_item.cmd == CMD_ENQUEUE) && !is_full;
  assign ctl.deq = accept && (in_item.cmd == CMD_DEQUEUE) && !is_none;

  // ---- the cell row: slot 0 is the front of the queue ----
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic                            lk;
      logic signed [31:0]              ld, rd;
      logic signed [PRIORITY_BITS-1:0] lp, rp;

      assign cell_occ[gi] = (count_r > CNT_W'(gi));

      if (gi == 0) begin : g_first
        // nothing ahead of the front slot: an insert ahead of its entry lands here
        assign lk = 1'b1;
        assign ld = in_item.item_data;
        assign lp = new_prio;
      end else begin : g_mid
        assign lk = cell_keep[gi-1];
        assign ld = cell_data[gi-1];
        assign lp = cell_prio[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        // tail slot falls out of use on dequeue; contents don't matter
        assign rd = cell_data[gi];
        assign rp = cell_prio[gi];
      end else begin : g_inner
        assign rd = cell_data[gi+1];
        assign rp = cell_prio[gi+1];
      end

      spq_cell #(
        .PRIO_W (PRIORITY_BITS)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (cell_occ[gi]),
        .left_keep  (lk),
        .new_data   (in_item.item_data),
        .new_prio   (new_prio),
        .left_data  (ld),
        .left_prio  (lp),
        .right_data (rd),
        .right_prio (rp),
        .keep       (cell_keep[gi]),
        .data       (cell_data[gi]),
        .prio       (cell_prio[gi])
      );
    end
  endgenerate

  // ---- count and result ----
  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // fill count reported modulo 32
  assign count_ext = (CNT_W + 5)'(count_nxt);

  always_comb begin
    out_nxt.front_data = '0;
    out_nxt.status     = ST_OK;
    unique case (in_item.cmd)
      CMD_ENQUEUE: begin
        if (is_full) begin
          out_nxt.status = ST_FULL;
        end
      end
      CMD_DEQUEUE, CMD_PEEK: begin
        if (is_none) begin
          out_nxt.status = ST_UNDERFLOW;
        end else begin
          out_nxt.front_data = cell_data[0];
        end
      end
      default: begin
        // unused code: no operation
      end
    endcase
    out_nxt.is_empty   = (count_nxt == '0);
    out_nxt.fill_count = count_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

endmodule : sorted_priority_queue

`default_nettype wire

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; keeps, takes the new entry, or takes a neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell import spq_pkg::*; #(
  parameter int PRIO_W = PRIORITY_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire spq_ctl_t                 ctl,
  input  wire logic                     occ,        // slot holds a live entry
  input  wire logic                     left_keep,  // left slot stays put on insert
  input  wire logic signed [31:0]       new_data,
  input  wire logic signed [PRIO_W-1:0] new_prio,
  input  wire logic signed [31:0]       left_data,
  input  wire logic signed [PRIO_W-1:0] left_prio,
  input  wire logic signed [31:0]       right_data,
  input  wire logic signed [PRIO_W-1:0] right_prio,
  output logic                          keep,
  output logic signed [31:0]            data,
  output logic signed [PRIO_W-1:0]      prio
);

  logic signed [31:0]       data_r, data_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;

  // equal priorities stay ahead of the newcomer: FIFO among ties
  assign keep = occ && (prio_r <= new_prio);

  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (ctl.enq && !keep) begin
      if (left_keep) begin
        data_nxt = new_data;
        prio_nxt = new_prio;
      end else begin
        data_nxt = left_data;
        prio_nxt = left_prio;
      end
    end else if (ctl.deq) begin
      data_nxt = right_data;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule : spq_cell

`default_nettype wire

// ===== dv/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue
// Drives enqueue, dequeue, peek and the unused command code through the start
// handshake. A shadow copy of the sorted list predicts every result, and a
// scoreboard matches each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 60000;   // far above the slowest legal run
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Traffic mixes for the random phases
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  spq_in_t  in_item;
  logic     out_strobe;
  spq_out_t out_result;

  sorted_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow of the queue contents, kept in service order (index 0 = front)
  // --------------------------------------------------------------------------
  logic        [31:0] shadow_data [DEPTH];
  logic signed [15:0] shadow_prio [DEPTH];
  int                 shadow_count;

  spq_out_t pending_results[$];   // predicted results, oldest first
  int       error_count;
  int       cycle_count;
  bit       gaps_on;              // sender idles at random when set

  // Run statistics for the summary
  int n_enq, n_full, n_deq, n_peek, n_underflow, n_unused;

  // Apply one transaction to the shadow list and return the result it causes.
  // Enqueue goes behind every entry with priority <= its own, which keeps
  // equal priorities first in, first out.
  function automatic spq_out_t predict_queue_op(spq_in_t it);
    spq_out_t r;
    int       pos;
    bit       found;
    r        = '0;
    r.status = ST_OK;
    found    = 1'b0;
    case (it.cmd)
      CMD_ENQUEUE: begin
        n_enq++;
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;   // dropped, list untouched
          n_full++;
        end else begin
          pos = shadow_count;
          for (int i = 0; i < shadow_count; i++) begin
            if (!found && shadow_prio[i] > it.item_priority) begin
              pos   = i;
              found = 1'b1;
            end
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_data[i] = shadow_data[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_data[pos] = it.item_data;
          shadow_prio[pos] = it.item_priority;
          shadow_count++;
        end
      end
      CMD_DEQUEUE, CMD_PEEK: begin
        if (it.cmd == CMD_DEQUEUE) n_deq++;
        else n_peek++;
        if (shadow_count == 0) begin
          r.status = ST_UNDERFLOW;   // front_data stays zero
          n_underflow++;
        end else begin
          r.front_data = shadow_data[0];
          if (it.cmd == CMD_DEQUEUE) begin
            for (int i = 1; i < shadow_count; i++) begin
              shadow_data[i-1] = shadow_data[i];
              shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
          end
        end
      end
      default: n_unused++;   // unused code: no operation, plain ok result
    endcase
    r.is_empty   = (shadow_count == 0);
    r.fill_count = shadow_count[4:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: sampled at the rising edge. Results due to a transaction taken
  // at this edge come from registered outputs and show up only after it, so checking before pushing is safe.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      error_count++;
      if (error_count <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                 want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    spq_out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 40)
            $display("%0t: unexpected result, expected none, actual %p",
                     $time, out_result);
        end else begin
          want = pending_results.pop_front();
          check_field("front_data", want.front_data, out_result.front_data);
          check_field("status",     want.status,     out_result.status);
          check_field("is_empty",   want.is_empty,   out_result.is_empty);
          check_field("fill_count", want.fill_count, out_result.fill_count);
        end
      end
      if (start && !busy) pending_results.push_back(predict_queue_op(in_item));
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic spq_in_t mk_item(logic [1:0] cmd, logic [31:0] data,
                                      logic [15:0] prio);
    spq_in_t it;
    it.cmd           = cmd;
    it.item_data     = data;
    it.item_priority = prio;
    return it;
  endfunction

  // Send one transaction. start is only lowered during an idle gap, so a
  // back-to-back transaction keeps it high with a single update per edge.
  task automatic send_item(input spq_in_t it);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 19) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every outstanding result has been seen
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Priorities bunch into a narrow band so ties are common; full-range and
  // extreme values turn up too
  function automatic logic [15:0] rand_prio();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 16'($signed($urandom_range(0, 6)) - 3);
    if (sel < 90) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic spq_in_t rand_item(mix_t mix);
    int         sel;
    int         enq_pct, deq_pct, peek_pct;
    logic [1:0] cmd;
    case (mix)
      MIX_FILL:  begin enq_pct = 75; deq_pct = 15; peek_pct = 7;  end
      MIX_DRAIN: begin enq_pct = 20; deq_pct = 65; peek_pct = 12; end
      default:   begin enq_pct = 46; deq_pct = 39; peek_pct = 12; end
    endcase
    sel = $urandom_range(0, 99);
    if (sel < enq_pct)                           cmd = CMD_ENQUEUE;
    else if (sel < enq_pct + deq_pct)            cmd = CMD_DEQUEUE;
    else if (sel < enq_pct + deq_pct + peek_pct) cmd = CMD_PEEK;
    else                                         cmd = CMD_UNUSED;
    return mk_item(cmd, rand_data(), rand_prio());
  endfunction

  // Random traffic in phases of 40 transactions with a randomly chosen mix
  task automatic run_random(input int count);
    mix_t mix;
    mix = MIX_BALANCED;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) mix = mix_t'($urandom_range(0, 2));
      send_item(rand_item(mix));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Underflow on an empty list, the unused code, a full fill mixing extreme
  // and tied priorities, the dropped enqueue when full, then peek and dequeue
  task automatic test_directed();
    logic [15:0] fill_prio [16] = '{16'h0000, 16'h8000, 16'h7fff, 16'h0000,
                                    16'h0005, 16'h0005, 16'h0005, 16'h8000,
                                    16'h7fff, 16'hffff, 16'h0001, 16'h0064,
                                    16'hff9c, 16'h0005, 16'h0000, 16'h8000};
    logic [31:0] fill_data [16] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                                    32'hffff_ffff, 32'h0000_0001, 32'h0000_0002,
                                    32'h0000_0003, 32'h5555_5555, 32'haaaa_aaaa,
                                    32'h0000_00ff, 32'h1234_5678, 32'h0bad_f00d,
                                    32'hdead_beef, 32'h0000_0004, 32'h0f0f_0f0f,
                                    32'hf0f0_f0f0};
    send_item(mk_item(CMD_DEQUEUE, 32'hffff_ffff, 16'hffff));
    send_item(mk_item(CMD_PEEK,    32'h0,         16'h0));
    send_item(mk_item(CMD_UNUSED,  32'hffff_ffff, 16'hffff));
    for (int i = 0; i < DEPTH; i++)
      send_item(mk_item(CMD_ENQUEUE, fill_data[i], fill_prio[i]));
    // full: this one would have gone behind the tied 16'h8000 entries at the front
    send_item(mk_item(CMD_ENQUEUE, 32'hcafe_cafe, 16'h8000));
    send_item(mk_item(CMD_UNUSED,  32'h0,         16'h0));
    send_item(mk_item(CMD_PEEK,    32'h0,         16'h0));
    send_item(mk_item(CMD_DEQUEUE, 32'h0,         16'h0));
    send_item(mk_item(CMD_DEQUEUE, 32'h0,         16'h0));
  endtask

  // Bulk random traffic with idle gaps from the sender
  task automatic test_random_mix();
    gaps_on = 1'b1;
    run_random(900);
  endtask

  // Back-to-back transactions, one per clock
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    run_random(250);
    gaps_on = 1'b1;
  endtask

  // Sender stops until the list of outstanding results is empty, then resumes
  task automatic test_drain_pause();
    run_random(60);
    wait_for_results();
    run_random(90);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    gaps_on      = 1'b1;
    shadow_count = 0;
    error_count  = 0;
    n_enq = 0; n_full = 0; n_deq = 0; n_peek = 0; n_underflow = 0; n_unused = 0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_data[i] = '0;
      shadow_prio[i] = '0;
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix();
    test_back_to_back();
    test_drain_pause();

    // Let the last results through, then a short tail for any stray strobe
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Run covered %0d enqueues (%0d dropped as full), %0d dequeues,",
             n_enq, n_full, n_deq);
    $display("%0d peeks, %0d underflows and %0d unused-code transactions.",
             n_peek, n_underflow, n_unused);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", error_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
dv/tb_sorted_priority_queue.sv
